@@ hdl/lppd_pkg.sv @@
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types and constants for the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

  localparam logic [15:0] HEADER_BYTES    = 16'd6;
  localparam logic [15:0] CHECKSUM_INVERT = 16'hFFFF;

  // header byte positions
  localparam logic [15:0] POS_SIZE_LO   = 16'd0;
  localparam logic [15:0] POS_SIZE_HI   = 16'd1;
  localparam logic [15:0] POS_OPCODE_LO = 16'd2;
  localparam logic [15:0] POS_OPCODE_HI = 16'd3;
  localparam logic [15:0] POS_SUM_LO    = 16'd4;
  localparam logic [15:0] POS_SUM_HI    = 16'd5;

  localparam int TDATA_W = 48;
  localparam int TUSER_W = 1;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [15:0] frame_opcode;
    logic [15:0] payload_length;
    logic        frame_last;
    logic        checksum_ok;
    logic        length_error;
  } lppd_result_t;

endpackage

@@ hdl/lppd_parser.sv @@
// ----------------------------------------------------------------------------
// lppd_parser
// Input register and frame parser: header assembly, payload sum, frame end.
// ----------------------------------------------------------------------------
module lppd_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  out_ready,
  output logic                  res_valid,
  output lppd_pkg::lppd_result_t res
);

  logic        st_valid;
  logic [7:0]  st_byte;
  logic        process;

  logic [15:0] byte_position, byte_position_next;
  logic [15:0] frame_size, frame_size_next;
  logic [15:0] opcode_hold, opcode_hold_next;
  logic [15:0] received_sum, received_sum_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;

  logic [15:0] word;
  logic [15:0] sum_add;
  logic        last;

  assign s_tready = !st_valid || out_ready;
  assign process  = st_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (s_tready) begin
      st_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      st_byte <= s_tdata;
    end
  end

  always_comb begin
    word               = {st_byte, low_byte_hold};
    sum_add            = running_sum + {8'd0, st_byte};
    last               = ({1'b0, byte_position} + 17'd1) >= {1'b0, frame_size};
    byte_position_next = byte_position;
    frame_size_next    = frame_size;
    opcode_hold_next   = opcode_hold;
    received_sum_next  = received_sum;
    running_sum_next   = running_sum;
    low_byte_hold_next = low_byte_hold;
    res_valid          = 1'b0;
    res                = '0;
    res.frame_opcode   = opcode_hold;
    if (byte_position < lppd_pkg::HEADER_BYTES) begin
      case (byte_position)
        lppd_pkg::POS_SIZE_LO, lppd_pkg::POS_OPCODE_LO, lppd_pkg::POS_SUM_LO: begin
          low_byte_hold_next = st_byte;
          byte_position_next = byte_position + 16'd1;
        end
        lppd_pkg::POS_SIZE_HI: begin
          frame_size_next    = word;
          byte_position_next = lppd_pkg::POS_OPCODE_LO;
        end
        lppd_pkg::POS_OPCODE_HI: begin
          opcode_hold_next   = word;
          byte_position_next = lppd_pkg::POS_SUM_LO;
        end
        default: begin
          received_sum_next = word;
          running_sum_next  = '0;
          if (frame_size <= lppd_pkg::HEADER_BYTES) begin
            res_valid          = st_valid;
            res.frame_last     = 1'b1;
            res.length_error   = frame_size < lppd_pkg::HEADER_BYTES;
            res.checksum_ok    = word == lppd_pkg::CHECKSUM_INVERT;
            byte_position_next = lppd_pkg::POS_SIZE_LO;
          end else begin
            byte_position_next = lppd_pkg::HEADER_BYTES;
          end
        end
      endcase
    end else begin
      running_sum_next   = sum_add;
      res_valid          = st_valid;
      res.payload_byte   = st_byte;
      res.payload_valid  = 1'b1;
      res.payload_length = frame_size - lppd_pkg::HEADER_BYTES;
      res.frame_last     = last;
      res.checksum_ok    = last && ((sum_add ^ lppd_pkg::CHECKSUM_INVERT) == received_sum);
      byte_position_next = last ? lppd_pkg::POS_SIZE_LO : byte_position + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      frame_size    <= '0;
      opcode_hold   <= '0;
      received_sum  <= '0;
      running_sum   <= '0;
      low_byte_hold <= '0;
    end else if (process) begin
      byte_position <= byte_position_next;
      frame_size    <= frame_size_next;
      opcode_hold   <= opcode_hold_next;
      received_sum  <= received_sum_next;
      running_sum   <= running_sum_next;
      low_byte_hold <= low_byte_hold_next;
    end
  end

  a_len_err_ends_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.length_error |-> res.frame_last && !res.payload_valid)
    else $error("length error result without frame end");

  a_payload_needs_size: assert property (@(posedge clk) disable iff (rst)
    byte_position >= lppd_pkg::HEADER_BYTES |-> frame_size > lppd_pkg::HEADER_BYTES)
    else $error("payload position with short frame size");

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    process && res_valid && res.payload_valid && !res.frame_last
    |=> byte_position == $past(byte_position) + 16'd1)
    else $error("byte position did not advance on payload transfer");

  a_frame_end_resets: assert property (@(posedge clk) disable iff (rst)
    process && res_valid && res.frame_last |=> byte_position == lppd_pkg::POS_SIZE_LO)
    else $error("byte position not cleared at frame end");

endmodule

@@ hdl/lppd_out_reg.sv @@
// ----------------------------------------------------------------------------
// lppd_out_reg
// Result register driving the master-side stream; packs result fields.
// ----------------------------------------------------------------------------
module lppd_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          res_valid,
  input  lppd_pkg::lppd_result_t        res,
  output logic                          out_ready,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lppd_pkg::TDATA_W-1:0]  m_tdata,
  output logic [lppd_pkg::TUSER_W-1:0]  m_tuser,
  output logic                          m_tlast
);

  lppd_pkg::lppd_result_t hold;

  assign out_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= res_valid;
    end
    if (out_ready && res_valid) begin
      hold <= res;
    end
  end

  assign m_tdata = {6'd0, hold.length_error, hold.checksum_ok, hold.payload_length,
                    hold.frame_opcode, hold.payload_byte};
  assign m_tuser = hold.payload_valid;
  assign m_tlast = hold.frame_last;

endmodule

@@ hdl/length_prefixed_packet_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_unit
// Splits a byte stream into frames with a 6-byte little-endian header.
// ----------------------------------------------------------------------------
// One byte is taken per cycle unless back-pressure from m_tready stalls the
// input; each byte passes the input register, then the result register. The
// per-byte work is one 16-bit add and compare in the parser. Header bytes give
// no transfer, except the last header byte of a frame with size six or less.
// Payload bytes come out with payload_valid in tuser and the frame end in tlast,
// carrying the checksum and length error flags. A partial frame waits without timeout.
module length_prefixed_packet_deframer_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,  // [7:0] rx_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [7:0] payload_byte, [23:8] frame_opcode, [39:24] payload_length,
  // [40] checksum_ok, [41] length_error, [47:42] zero
  output logic [lppd_pkg::TDATA_W-1:0] m_tdata,
  output logic [lppd_pkg::TUSER_W-1:0] m_tuser,  // [0] payload_valid
  output logic                         m_tlast   // frame_last
);

  logic                   res_valid;
  logic                   out_ready;
  lppd_pkg::lppd_result_t res;

  lppd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .out_ready (out_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  lppd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

@@ sim/tb_length_prefixed_packet_deframer_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_packet_deframer_unit
// Streams framed bytes into the deframer and checks every output transfer
// against an internal prediction of the frame parser. Directed frames cover
// short, empty and one-byte frames; random traffic mixes good and bad
// checksums, odd sizes and junk runs, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_length_prefixed_packet_deframer_unit;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  class payload_scoreboard;
    logic [15:0]            pos;
    logic [15:0]            size_field;
    logic [15:0]            opcode;
    logic [15:0]            hdr_sum;
    logic [15:0]            pay_sum;
    logic [7:0]             lo_hold;
    lppd_pkg::lppd_result_t expected_q[$];
    int                     errors;

    function new();
      pos        = '0;
      size_field = '0;
      opcode     = '0;
      hdr_sum    = '0;
      pay_sum    = '0;
      lo_hold    = '0;
      errors     = 0;
    endfunction

    function logic [15:0] position();
      return pos;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // note one accepted rx byte and queue the transfer it should cause
    function void take_rx_byte(logic [7:0] b);
      lppd_pkg::lppd_result_t r;
      logic [15:0]            word;
      r    = '0;
      word = {b, lo_hold};
      if (pos < lppd_pkg::HEADER_BYTES) begin
        case (pos)
          lppd_pkg::POS_SIZE_LO, lppd_pkg::POS_OPCODE_LO, lppd_pkg::POS_SUM_LO: begin
            lo_hold = b;
            pos     = pos + 16'd1;
          end
          lppd_pkg::POS_SIZE_HI: begin
            size_field = word;
            pos        = pos + 16'd1;
          end
          lppd_pkg::POS_OPCODE_HI: begin
            opcode = word;
            pos    = pos + 16'd1;
          end
          default: begin
            hdr_sum = word;
            pay_sum = '0;
            if (size_field <= lppd_pkg::HEADER_BYTES) begin
              r.frame_opcode = opcode;
              r.frame_last   = 1'b1;
              r.checksum_ok  = (hdr_sum == lppd_pkg::CHECKSUM_INVERT);
              r.length_error = (size_field < lppd_pkg::HEADER_BYTES);
              expected_q.push_back(r);
              pos = '0;
            end else begin
              pos = lppd_pkg::HEADER_BYTES;
            end
          end
        endcase
      end else begin
        pay_sum          = pay_sum + {8'd0, b};
        r.payload_byte   = b;
        r.payload_valid  = 1'b1;
        r.frame_opcode   = opcode;
        r.payload_length = size_field - lppd_pkg::HEADER_BYTES;
        r.frame_last     = ({1'b0, pos} + 17'd1 >= {1'b0, size_field});
        r.checksum_ok    = r.frame_last &&
                           ((pay_sum ^ lppd_pkg::CHECKSUM_INVERT) == hdr_sum);
        pos = r.frame_last ? 16'd0 : pos + 16'd1;
        expected_q.push_back(r);
      end
    endfunction

    function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_payload(lppd_pkg::lppd_result_t got);
      lppd_pkg::lppd_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("output transfer with nothing expected: %p", got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      cmp_field("payload_byte", 16'(exp_r.payload_byte), 16'(got.payload_byte));
      cmp_field("payload_valid", 16'(exp_r.payload_valid), 16'(got.payload_valid));
      cmp_field("frame_opcode", exp_r.frame_opcode, got.frame_opcode);
      cmp_field("payload_length", exp_r.payload_length, got.payload_length);
      cmp_field("frame_last", 16'(exp_r.frame_last), 16'(got.frame_last));
      cmp_field("checksum_ok", 16'(exp_r.checksum_ok), 16'(got.checksum_ok));
      cmp_field("length_error", 16'(exp_r.length_error), 16'(got.length_error));
    endfunction
  endclass

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata  = 8'd0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [lppd_pkg::TDATA_W-1:0]  m_tdata;
  logic [lppd_pkg::TUSER_W-1:0]  m_tuser;
  logic                          m_tlast;

  payload_scoreboard sb = new();
  int                idle_pct = 37;
  int                items_sent = 0;

  length_prefixed_packet_deframer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk) begin
    lppd_pkg::lppd_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.payload_byte   = m_tdata[7:0];
      got.frame_opcode   = m_tdata[23:8];
      got.payload_length = m_tdata[39:24];
      got.checksum_ok    = m_tdata[40];
      got.length_error   = m_tdata[41];
      got.payload_valid  = m_tuser[0];
      got.frame_last     = m_tlast;
      sb.check_payload(got);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_rx_byte(b);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // pause_at: header byte index before which the sender waits for the output to drain
  task automatic send_frame(input logic [15:0] size, input logic [15:0] opc,
                            input bit good_sum, input fill_t fill, input int pause_at);
    logic [7:0]  pay[$];
    logic [7:0]  hdr[6];
    logic [7:0]  b;
    logic [15:0] s;
    logic [15:0] cks;
    int          plen;
    s    = '0;
    plen = (size > lppd_pkg::HEADER_BYTES) ? int'(size - lppd_pkg::HEADER_BYTES) : 0;
    for (int i = 0; i < plen; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      pay.push_back(b);
      s = s + {8'd0, b};
    end
    cks = s ^ lppd_pkg::CHECKSUM_INVERT;
    if (!good_sum) begin
      cks = 16'($urandom);
      if (cks == (s ^ lppd_pkg::CHECKSUM_INVERT)) cks = ~cks;
    end
    hdr = '{size[7:0], size[15:8], opc[7:0], opc[15:8], cks[7:0], cks[15:8]};
    for (int i = 0; i < 6; i++) begin
      if (i == pause_at) drain();
      send_byte(hdr[i]);
    end
    foreach (pay[i]) send_byte(pay[i]);
  endtask

  initial begin
    int          kind;
    int          n;
    bit          paused;
    logic [7:0]  b;
    paused = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short, empty and one-byte frames at the field extremes
    send_frame(16'd0, 16'hFFFF, 1'b1, FILL_RANDOM, -1);
    send_frame(16'd5, 16'h0000, 1'b0, FILL_RANDOM, -1);
    send_frame(16'd6, 16'h8001, 1'b1, FILL_RANDOM, -1);
    send_frame(16'd7, 16'h7FFE, 1'b1, FILL_ONES, -1);
    send_frame(16'd8, 16'h00FF, 1'b0, FILL_ZERO, -1);

    while (items_sent < 1450) begin
      idle_pct = (items_sent >= 500 && items_sent < 800) ? 0 : 37;
      kind = $urandom_range(0, 99);
      if (!paused && items_sent >= 1000) begin
        paused = 1'b1;
        send_frame(16'($urandom_range(7, 40)), 16'($urandom), 1'b1, FILL_RANDOM, 3);
      end else if (kind < 50) begin
        send_frame(16'($urandom_range(7, 40)), 16'($urandom), 1'b1, FILL_RANDOM, -1);
      end else if (kind < 65) begin
        send_frame(16'($urandom_range(7, 40)), 16'($urandom), 1'b0, FILL_RANDOM, -1);
      end else if (kind < 72) begin
        send_frame(lppd_pkg::HEADER_BYTES, 16'($urandom), 1'($urandom), FILL_RANDOM, -1);
      end else if (kind < 80) begin
        send_frame(16'($urandom_range(0, 5)), 16'($urandom), 1'($urandom), FILL_RANDOM, -1);
      end else if (kind < 85) begin
        send_frame(16'($urandom_range(100, 400)), 16'($urandom), 1'b1, FILL_RANDOM, -1);
      end else begin
        // junk run: size high byte kept small, then fill until the frame closes
        n = $urandom_range(1, 8);
        repeat (n) begin
          b = 8'($urandom);
          if (sb.position() == lppd_pkg::POS_SIZE_HI) b = 8'($urandom_range(0, 1));
          send_byte(b);
        end
        while (sb.position() != 16'd0) send_byte(8'($urandom));
      end
    end
    idle_pct = 37;

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
